// ===== hw/rtl/tvd_pkg.sv =====
// tvd_pkg: shared types and constants for the 1-D total-variation denoiser.
// No dependencies.
package tvd_pkg;

  localparam int SMP_W = 16;
  localparam int LAM_W = 15;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT,
    ST_TOP,
    ST_NEXT_RD,
    ST_STEP_LO,
    ST_STEP_HI,
    ST_ADV,
    ST_DIV_LO,
    ST_DIV_LO_W,
    ST_DIV_HI,
    ST_DIV_HI_W,
    ST_END_DIV,
    ST_END_DIV_W,
    ST_EMIT,
    ST_REST_RD,
    ST_REST,
    ST_READ,
    ST_READ_W
  } tvd_state_t;

  typedef enum logic [2:0] {
    EM_LO_LAST,
    EM_HI_LAST,
    EM_FINAL,
    EM_JUMP_LO,
    EM_JUMP_HI
  } tvd_emit_t;

  typedef struct packed {
    logic init_rd;
    logic init;
    logic next_rd;
    logic step_lo;
    logic step_hi;
    logic adv;
    logic div_lo_go;
    logic div_lo_done;
    logic div_hi_go;
    logic div_hi_done;
    logic end_go;
    logic end_done;
    logic emit_set;
    tvd_emit_t emit_kind;
    logic emit_step;
    logic rest_rd;
    logic rest;
    logic res_rd;
  } tvd_cmd_t;

  typedef struct packed {
    logic at_end;
    logic dl_neg;
    logic dh_pos;
    logic lo_jump;
    logic hi_jump;
    logic emit_more;
    logic seg_done;
    logic div_busy;
  } tvd_sts_t;

endpackage

// ===== hw/rtl/tvd_if.sv =====
// tvd_if: valid/ready channel interface with a generic payload.
// Depends on nothing.
interface tvd_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tv_denoise_1d.sv =====
// tv_denoise_1d: top level of the 1-D total-variation denoiser.
// Depends on tvd_pkg, tvd_if, tvd_ctrl, tvd_dp, tvd_div.
//
// Usage: the in channel carries opcode/sample/last. Loads (opcode 0) store
// one sample each. A load with last set starts the solve over the
// stored waveform; the channel stalls until the solver finishes. Solving
// runs two divisions per advance on the shared one-bit-per-cycle divider
// over the internal word width, plus backtracking and emit steps.
// Reads (opcode 1) go through the result memory and give one out
// transaction each; a stalled out channel holds the in channel.
// The cfg channel writes lambda; write it only while idle.
// Reset clears counters and flags; memories are undefined until written.
// Reads with nothing left return zeros with rd_valid low.
// Each read holds the in channel until its result is accepted on out.
//
module tv_denoise_1d
  import tvd_pkg::*;
#(
  parameter int MAX_LEN   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  tvd_if.sink   in_ch,
  tvd_if.source out_ch,
  tvd_if.sink   cfg_ch
);
  tvd_cmd_t cmd;
  tvd_sts_t sts;
  logic idle, read_ack, solve_go, ld_we, read_go, acc;
  logic [LAM_W-1:0] lambda_r;
  logic signed [SMP_W-1:0] rd_data;
  logic rd_eow, rd_valid, rd_trunc;
  logic ov_r;
  logic [SMP_W+2:0] od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) lambda_r <= '0;
    else if (cfg_ch.valid) lambda_r <= cfg_ch.data[LAM_W-1:0];
  end
  assign cfg_ch.ready = 1'b1;

  assign in_ch.ready = idle && !ov_r;
  assign acc     = in_ch.valid && in_ch.ready;
  assign ld_we   = acc && !in_ch.data[0];
  assign read_go = acc && in_ch.data[0];

  tvd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .solve_go(solve_go), .read_go(read_go),
    .sts(sts), .cmd(cmd), .idle(idle), .read_ack(read_ack)
  );

  tvd_dp #(.MAX_LEN(MAX_LEN), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .ld_we(ld_we), .ld_sample(in_ch.data[16:1]), .ld_last(in_ch.data[17]),
    .lambda(lambda_r), .solve_go(solve_go),
    .rd_data(rd_data), .rd_eow(rd_eow), .rd_valid(rd_valid), .rd_trunc(rd_trunc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (read_ack) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
    if (read_ack) od_r <= {rd_trunc, rd_valid, rd_eow, rd_data};
  end
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  a_ack_free: assert property (@(posedge clk) disable iff (!rst_n)
    read_ack |-> !ov_r) else $error("result overwritten");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> !acc) else $error("accept while busy");
  a_eow_valid: assert property (@(posedge clk) disable iff (!rst_n)
    read_ack && rd_eow |-> rd_valid) else $error("eow without valid");
endmodule

// ===== hw/rtl/tvd_div.sv =====
// tvd_div: restoring signed divider, one quotient bit per cycle, truncating.
// Depends on tvd_pkg.
module tvd_div
  import tvd_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 busy,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [NW:0]   rm_r, rm_nxt;
  logic [DW-1:0] d_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]   trial;

  always_comb begin
    trial   = {rm_r[NW-1:0], q_r[NW-1]};
    rm_nxt  = trial;
    q_nxt   = {q_r[NW-2:0], 1'b0};
    cnt_nxt = cnt_r;
    if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {{(NW+1-DW){1'b0}}, d_r}) begin
        rm_nxt   = trial - {{(NW+1-DW){1'b0}}, d_r};
        q_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CW'(NW);
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (go) begin
      q_r   <= num[NW-1] ? NW'(-num) : num;
      neg_r <= num[NW-1];
      d_r   <= den;
      rm_r  <= '0;
    end else if (cnt_r != '0) begin
      q_r  <= q_nxt;
      rm_r <= rm_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// ===== hw/rtl/tvd_ctrl.sv =====
// tvd_ctrl: solver and read sequencer state machine.
// Depends on tvd_pkg.
module tvd_ctrl
  import tvd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     solve_go,
  input  logic     read_go,
  input  tvd_sts_t sts,
  output tvd_cmd_t cmd,
  output logic     idle,
  output logic     read_ack
);
  tvd_state_t state_r, state_nxt;
  tvd_emit_t  ek_r, ek_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ek_r    <= EM_FINAL;
    end else begin
      state_r <= state_nxt;
      ek_r    <= ek_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ek_nxt        = ek_r;
    cmd           = '0;
    cmd.emit_kind = ek_r;
    idle          = 1'b0;
    read_ack      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (solve_go) begin
          state_nxt = ST_INIT_RD;
        end else if (read_go) begin
          cmd.res_rd = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_nxt   = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_TOP;
      end
      ST_TOP: begin
        if (sts.at_end) begin
          if (sts.dl_neg) begin
            ek_nxt = EM_LO_LAST; cmd.emit_set = 1'b1; cmd.emit_kind = EM_LO_LAST;
            state_nxt = ST_EMIT;
          end else if (sts.dh_pos) begin
            ek_nxt = EM_HI_LAST; cmd.emit_set = 1'b1; cmd.emit_kind = EM_HI_LAST;
            state_nxt = ST_EMIT;
          end else begin
            cmd.end_go = 1'b1;
            state_nxt  = ST_END_DIV;
          end
        end else begin
          cmd.next_rd = 1'b1;
          state_nxt   = ST_NEXT_RD;
        end
      end
      ST_NEXT_RD: begin
        cmd.step_lo = 1'b1;
        state_nxt   = ST_STEP_LO;
      end
      ST_STEP_LO: begin
        if (sts.lo_jump) begin
          ek_nxt = EM_JUMP_LO; cmd.emit_set = 1'b1; cmd.emit_kind = EM_JUMP_LO;
          state_nxt = ST_EMIT;
        end else begin
          cmd.step_hi = 1'b1;
          state_nxt   = ST_STEP_HI;
        end
      end
      ST_STEP_HI: begin
        if (sts.hi_jump) begin
          ek_nxt = EM_JUMP_HI; cmd.emit_set = 1'b1; cmd.emit_kind = EM_JUMP_HI;
          state_nxt = ST_EMIT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd.div_lo_go = 1'b1;
        state_nxt     = ST_DIV_LO;
      end
      ST_DIV_LO: state_nxt = ST_DIV_LO_W;
      ST_DIV_LO_W: begin
        if (!sts.div_busy) begin
          cmd.div_lo_done = 1'b1;
          cmd.div_hi_go   = 1'b1;
          state_nxt       = ST_DIV_HI;
        end
      end
      ST_DIV_HI: state_nxt = ST_DIV_HI_W;
      ST_DIV_HI_W: begin
        if (!sts.div_busy) begin
          cmd.div_hi_done = 1'b1;
          state_nxt       = ST_TOP;
        end
      end
      ST_END_DIV: state_nxt = ST_END_DIV_W;
      ST_END_DIV_W: begin
        if (!sts.div_busy) begin
          cmd.end_done = 1'b1;
          ek_nxt       = EM_FINAL;
          cmd.emit_set = 1'b1;
          cmd.emit_kind = EM_FINAL;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (!sts.emit_more) begin
          if (ek_r == EM_FINAL || sts.seg_done) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rest_rd = 1'b1;
            state_nxt   = ST_REST_RD;
          end
        end
      end
      ST_REST_RD: begin
        cmd.rest  = 1'b1;
        state_nxt = ST_REST;
      end
      ST_REST: state_nxt = ST_TOP;
      ST_READ: state_nxt = ST_READ_W;
      ST_READ_W: begin
        read_ack = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/tvd_dp.sv =====
// tvd_dp: sample/result memories, solver registers and divider.
// Depends on tvd_pkg and tvd_div.
module tvd_dp
  import tvd_pkg::*;
#(
  parameter int MAX_LEN   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tvd_cmd_t                cmd,
  output tvd_sts_t                sts,
  input  logic                    ld_we,
  input  logic signed [SMP_W-1:0] ld_sample,
  input  logic                    ld_last,
  input  logic [LAM_W-1:0]        lambda,
  output logic                    solve_go,
  output logic signed [SMP_W-1:0] rd_data,
  output logic                    rd_eow,
  output logic                    rd_valid,
  output logic                    rd_trunc
);
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int VW = SMP_W + FRAC_BITS + CW + 4;
  localparam int PW = CW + 1;
  localparam logic signed [VW-1:0] HALF_V = VW'((64'd1 << FRAC_BITS) >> 1);

  logic signed [SMP_W-1:0] smem [MAX_LEN];
  logic signed [SMP_W-1:0] rmem [MAX_LEN];
  logic signed [SMP_W-1:0] sq_r, rq_r;

  logic [CW-1:0] cnt_r, n_r, rcnt_r, rp_r;
  logic          ovf_r, trunc_r, ready_r;
  logic [PW-1:0] ss_r, cp_r, llp_r, lhp_r, upto_r;
  logic signed [VW-1:0] lo_r, hi_r, dl_r, dh_r, lam_r, ev_r;
  logic [AW-1:0] raddr;
  logic          sread;

  logic signed [VW-1:0] lam_v, fv, rsum, rval;
  logic signed [SMP_W-1:0] rsat;
  logic signed [VW-1:0] dnum, dq, dl_t, dh_t;
  logic [PW-1:0] seglen;
  logic          dgo, dbusy;
  logic [PW-1:0] ss_inc;

  assign lam_v = VW'($signed({1'b0, lambda})) <<< FRAC_BITS;
  assign fv    = VW'(sq_r) <<< FRAC_BITS;
  assign dl_t  = dl_r + fv - lo_r;
  assign dh_t  = dh_r + fv - hi_r;
  assign seglen = cp_r - ss_r + 1'b1;
  assign ss_inc = ss_r + 1'b1;

  // round half up, saturate
  always_comb begin
    rsum = (ev_r + HALF_V) >>> FRAC_BITS;
    rval = rsum;
    if (rsum > VW'(32767)) rsat = 16'sh7fff;
    else if (rsum < -VW'(32768)) rsat = -16'sh8000;
    else rsat = rval[SMP_W-1:0];
  end

  always_comb begin
    sread = 1'b1;
    raddr = AW'(ss_r);
    if (cmd.next_rd) raddr = AW'(cp_r + 1'b1);
    else if (cmd.init_rd) raddr = '0;
    else if (cmd.rest_rd) raddr = AW'(ss_inc);
    else sread = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ld_we && cnt_r < CW'(MAX_LEN)) smem[AW'(cnt_r)] <= ld_sample;
    if (sread) sq_r <= smem[raddr];
    if (cmd.emit_step && ss_r < PW'(MAX_LEN)) rmem[AW'(ss_r)] <= rsat;
    if (cmd.res_rd) rq_r <= rmem[AW'(rp_r)];
  end

  assign solve_go = ld_we && ld_last;

  always_comb begin
    dnum = dl_r - lam_r;
    if (cmd.div_hi_go) dnum = dh_r + lam_r;
    if (cmd.end_go) dnum = dl_r;
  end
  assign dgo = cmd.div_lo_go || cmd.div_hi_go || cmd.end_go;

  tvd_div #(.NW(VW), .DW(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(seglen),
    .busy(dbusy), .quo(dq)
  );

  logic lo_hit_r, hi_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ovf_r <= 1'b0; ready_r <= 1'b0; trunc_r <= 1'b0;
      rp_r <= '0; rcnt_r <= '0; n_r <= '0;
      ss_r <= '0; cp_r <= '0; llp_r <= '0; lhp_r <= '0; upto_r <= '0;
      lo_r <= '0; hi_r <= '0; dl_r <= '0; dh_r <= '0; lam_r <= '0; ev_r <= '0;
      lo_hit_r <= 1'b0; hi_hit_r <= 1'b0;
    end else begin
      if (ld_we) begin
        logic [CW-1:0] c1;
        c1 = (cnt_r < CW'(MAX_LEN)) ? cnt_r + 1'b1 : cnt_r;
        if (ld_last) begin
          n_r <= c1; rcnt_r <= c1; trunc_r <= ovf_r || cnt_r >= CW'(MAX_LEN);
          ready_r <= 1'b1; rp_r <= '0; cnt_r <= '0; ovf_r <= 1'b0;
          lam_r <= lam_v;
        end else begin
          cnt_r <= c1;
          if (cnt_r >= CW'(MAX_LEN)) ovf_r <= 1'b1;
        end
      end
      if (cmd.res_rd) begin
        rp_r <= rp_r + 1'b1;
        if (rp_r + 1'b1 == rcnt_r) ready_r <= 1'b0;
      end
      if (cmd.init) begin
        ss_r <= '0; cp_r <= '0; llp_r <= '0; lhp_r <= '0;
        dl_r <= lam_r; dh_r <= -lam_r;
        lo_r <= fv - lam_r; hi_r <= fv + lam_r;
      end
      if (cmd.step_lo) dl_r <= dl_t;
      if (cmd.step_hi) dh_r <= dh_t;
      if (cmd.adv) begin
        cp_r <= cp_r + 1'b1;
        lo_hit_r <= dl_r >= lam_r;
        hi_hit_r <= dh_r <= -lam_r;
        if (dl_r >= lam_r) llp_r <= cp_r + 1'b1;
        if (dh_r <= -lam_r) lhp_r <= cp_r + 1'b1;
      end
      if (cmd.div_lo_done && lo_hit_r) begin
        lo_r <= lo_r + dq; dl_r <= lam_r;
      end
      if (cmd.div_hi_done && hi_hit_r) begin
        hi_r <= hi_r + dq; dh_r <= -lam_r;
      end
      if (cmd.end_done) lo_r <= lo_r + dq;
      if (cmd.emit_set) begin
        unique case (cmd.emit_kind)
          EM_LO_LAST, EM_JUMP_LO: begin ev_r <= lo_r; upto_r <= llp_r; end
          EM_HI_LAST, EM_JUMP_HI: begin ev_r <= hi_r; upto_r <= lhp_r; end
          EM_FINAL: begin ev_r <= lo_r + dq; upto_r <= cp_r; end
          default: begin ev_r <= lo_r; upto_r <= cp_r; end
        endcase
      end
      if (cmd.emit_step) ss_r <= ss_inc;
      if (cmd.rest) begin
        unique case (cmd.emit_kind)
          EM_LO_LAST: begin
            cp_r <= ss_r;
            llp_r <= ss_r; lo_r <= fv; dl_r <= lam_r; dh_r <= fv + lam_r - hi_r;
          end
          EM_HI_LAST: begin
            cp_r <= ss_r;
            lhp_r <= ss_r; hi_r <= fv; dh_r <= -lam_r; dl_r <= fv - lam_r - lo_r;
          end
          EM_JUMP_LO: begin
            cp_r <= ss_r;
            llp_r <= ss_r; lhp_r <= ss_r; lo_r <= fv; hi_r <= fv + (lam_r <<< 1);
            dl_r <= lam_r; dh_r <= -lam_r;
          end
          EM_JUMP_HI: begin
            cp_r <= ss_r;
            llp_r <= ss_r; lhp_r <= ss_r; hi_r <= fv; lo_r <= fv - (lam_r <<< 1);
            dl_r <= lam_r; dh_r <= -lam_r;
          end
          default: cp_r <= ss_r;
        endcase
      end
    end
  end

  assign sts.at_end    = (cp_r == PW'(n_r) - 1'b1);
  assign sts.dl_neg    = dl_r < 0;
  assign sts.dh_pos    = dh_r > 0;
  assign sts.lo_jump   = dl_r < -lam_r;
  assign sts.hi_jump   = dh_r > lam_r;
  assign sts.emit_more = (ss_inc <= upto_r) && (ss_inc < PW'(n_r));
  assign sts.seg_done  = ss_inc >= PW'(n_r);
  assign sts.div_busy  = dbusy;

  logic rd_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_ok_r <= 1'b0;
    else if (cmd.res_rd) rd_ok_r <= ready_r && rp_r < rcnt_r;
  end
  logic eow_r;
  always_ff @(posedge clk) begin
    if (cmd.res_rd) eow_r <= (rp_r + 1'b1 == rcnt_r);
  end

  assign rd_valid = rd_ok_r;
  assign rd_data  = rd_ok_r ? rq_r : '0;
  assign rd_eow   = rd_ok_r && eow_r;
  assign rd_trunc = rd_ok_r && trunc_r;
endmodule
